>>> src/lstp_pkg.sv
// ----------------------------------------------------------------------------
// lstp_pkg: scan telegram parser shared definitions
// Field positions, result codes, the result record and the hex digit decoder.
// ----------------------------------------------------------------------------
package lstp_pkg;

  // default layout of a telegram
  localparam int EXPECTED_FIELDS_DEF   = 124;
  localparam int FIRST_RANGE_FIELD_DEF = 27;
  localparam int RANGE_POINTS_DEF      = 91;

  // fixed header fields, counted from 0
  localparam int FREQ_FIELD  = 17;
  localparam int START_FIELD = 24;
  localparam int STEP_FIELD  = 25;

  // token separator
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // result queue depth, room for two results per byte plus drain slack
  localparam int RES_DEPTH = 4;

  // field widths of one result
  localparam int RANGE_W = 16;
  localparam int INDEX_W = 7;
  localparam int FREQ_W  = 16;
  localparam int ANGLE_W = 32;
  localparam int STEP_W  = 16;
  localparam int RUN_W   = 34;

  // configuration register indexes
  typedef enum logic {
    REG_MIN_ANGLE = 1'b0,
    REG_MAX_ANGLE = 1'b1
  } reg_index_t;

  // result kinds
  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // summary field-count status
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_TOO_MANY = 2'd2
  } status_t;

  // one result item
  typedef struct packed {
    kind_t                      kind;
    logic [RANGE_W-1:0]         range_mm;
    logic [INDEX_W-1:0]         point_index;
    status_t                    status;
    logic [FREQ_W-1:0]          scan_frequency;
    logic signed [ANGLE_W-1:0]  start_angle;
    logic [STEP_W-1:0]          angle_step;
    logic                       last;
  } res_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b1, 4'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage

>>> src/lidar_scan_telegram_parser_top.sv
// Path: an accepted byte lands in the input register and is then processed into the result queue.
// Throughput: one byte per cycle while the result queue has room for two results; a final
// byte closing a passing range token yields two results, drained through a four-entry queue.
// Reset: rst clears the telegram state, the window registers to the full range
// and empties the result queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lidar_scan_telegram_parser_top: ASCII scan telegram parser
// Splits the byte stream into space-separated hex tokens, keeps the header
// fields and emits range points that fall into the angle window, then a summary.
// ----------------------------------------------------------------------------
module lidar_scan_telegram_parser_top #(
  parameter int EXPECTED_FIELDS   = lstp_pkg::EXPECTED_FIELDS_DEF,
  parameter int FIRST_RANGE_FIELD = lstp_pkg::FIRST_RANGE_FIELD_DEF,
  parameter int RANGE_POINTS      = lstp_pkg::RANGE_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_telegram
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // range_mm, point_index, status,
                                      // scan_frequency, start_angle, angle_step
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W   = $clog2(EXPECTED_FIELDS + 2);
  localparam int PTR_W   = $clog2(lstp_pkg::RES_DEPTH);
  localparam int FILL_W  = $clog2(lstp_pkg::RES_DEPTH + 1);
  localparam int RANGE_END = FIRST_RANGE_FIELD + RANGE_POINTS;
  localparam int CMP_W   = lstp_pkg::RUN_W + 1;

  // window registers
  logic signed [31:0] min_angle;
  logic signed [31:0] max_angle;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // telegram state
  logic                             inside_token, inside_token_next;
  logic [CNT_W-1:0]                 token_count, token_count_next;
  logic [31:0]                      hex_value, hex_value_next;
  logic                             hex_stopped, hex_stopped_next;
  logic                             hex_digit_seen, hex_digit_seen_next;
  logic [lstp_pkg::FREQ_W-1:0]      held_frequency, held_frequency_next;
  logic [31:0]                      held_start_angle, held_start_angle_next;
  logic [lstp_pkg::STEP_W-1:0]      held_step, held_step_next;
  logic signed [lstp_pkg::RUN_W-1:0] running_angle, running_angle_next;
  logic [lstp_pkg::INDEX_W-1:0]     emitted_points, emitted_points_next;

  // result queue
  lstp_pkg::res_t   res_mem [lstp_pkg::RES_DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [FILL_W-1:0] fill;

  // byte processing
  logic             proc;
  logic             is_space, opening, closing;
  logic [4:0]       dig;
  logic [CNT_W-1:0] cnt1;
  logic [31:0]      hv1, hv2;
  logic             stop1, stop2, seen1, seen2, inside1;
  logic [31:0]      idx_ext;
  logic             field_ok, pt_hit;
  logic signed [CMP_W-1:0] ang_ext, step_ext, ang_plus, ang_minus;
  lstp_pkg::res_t   point_res, sum_res, push0, push1;
  logic [1:0]       n_push;
  logic             pop;

  // config port always takes writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle <= 32'sh8000_0000;
      max_angle <= 32'sh7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (lstp_pkg::reg_index_t'(cfg_index))
        lstp_pkg::REG_MIN_ANGLE: min_angle <= cfg_data;
        lstp_pkg::REG_MAX_ANGLE: max_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  // process when the queue has room for two results
  assign proc          = in_valid && (fill <= FILL_W'(lstp_pkg::RES_DEPTH - 2));
  assign s_axis_tready = !in_valid || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  // token open and hex accumulate
  always_comb begin
    is_space = (in_byte == lstp_pkg::SPACE_CHAR);
    opening  = !is_space && !inside_token;
    dig      = lstp_pkg::hex_digit(in_byte);
    cnt1     = (opening && token_count <= CNT_W'(EXPECTED_FIELDS))
               ? token_count + CNT_W'(1) : token_count;
    hv1      = opening ? 32'd0 : hex_value;
    stop1    = opening ? 1'b0 : hex_stopped;
    seen1    = opening ? 1'b0 : hex_digit_seen;
    hv2      = hv1;
    stop2    = stop1;
    seen2    = seen1;
    if (!is_space && !stop1) begin
      if (dig[4]) begin
        hv2   = {hv1[27:0], dig[3:0]};
        seen2 = 1'b1;
      end else begin
        stop2 = 1'b1;
      end
    end
    inside1 = is_space ? inside_token : 1'b1;
    closing = is_space ? inside_token : (in_end && inside1);
  end

  // window test on the running angle
  always_comb begin
    ang_ext   = CMP_W'(running_angle);
    step_ext  = CMP_W'($signed({1'b0, held_step}));
    ang_plus  = ang_ext + step_ext;
    ang_minus = ang_ext - step_ext;
  end

  // token close, header capture and range point
  always_comb begin
    idx_ext  = 32'(cnt1) - 32'd1;
    field_ok = closing && (cnt1 != '0) && (cnt1 <= CNT_W'(EXPECTED_FIELDS));

    held_frequency_next   = held_frequency;
    held_start_angle_next = held_start_angle;
    held_step_next        = held_step;
    running_angle_next    = running_angle;
    emitted_points_next   = emitted_points;
    pt_hit                = 1'b0;

    if (field_ok) begin
      if (idx_ext == 32'(lstp_pkg::FREQ_FIELD)) begin
        if (seen2) held_frequency_next = hv2[lstp_pkg::FREQ_W-1:0];
      end else if (idx_ext == 32'(lstp_pkg::START_FIELD)) begin
        if (seen2) held_start_angle_next = hv2;
        running_angle_next = lstp_pkg::RUN_W'($signed(held_start_angle_next));
      end else if (idx_ext == 32'(lstp_pkg::STEP_FIELD)) begin
        if (seen2) held_step_next = hv2[lstp_pkg::STEP_W-1:0];
      end else if (idx_ext >= 32'(FIRST_RANGE_FIELD) && idx_ext < 32'(RANGE_END)) begin
        running_angle_next = ang_plus[lstp_pkg::RUN_W-1:0];
        if (ang_plus >= CMP_W'(min_angle) && ang_minus <= CMP_W'(max_angle)) begin
          pt_hit              = 1'b1;
          emitted_points_next = emitted_points + lstp_pkg::INDEX_W'(1);
        end
      end
    end
  end

  // result records
  always_comb begin
    point_res             = '0;
    point_res.kind        = lstp_pkg::KIND_POINT;
    point_res.range_mm    = seen2 ? hv2[lstp_pkg::RANGE_W-1:0] : '0;
    point_res.point_index = emitted_points;
    point_res.status      = lstp_pkg::STATUS_OK;

    sum_res      = '0;
    sum_res.kind = lstp_pkg::KIND_SUMMARY;
    if (cnt1 < CNT_W'(EXPECTED_FIELDS)) begin
      sum_res.status = lstp_pkg::STATUS_TOO_FEW;
    end else if (cnt1 > CNT_W'(EXPECTED_FIELDS)) begin
      sum_res.status = lstp_pkg::STATUS_TOO_MANY;
    end else begin
      sum_res.status = lstp_pkg::STATUS_OK;
    end
    sum_res.scan_frequency = held_frequency_next;
    sum_res.start_angle    = held_start_angle_next;
    sum_res.angle_step     = held_step_next;
    sum_res.last           = 1'b1;

    push0  = pt_hit ? point_res : sum_res;
    push1  = sum_res;
    n_push = proc ? (2'(pt_hit) + 2'(in_end)) : 2'd0;
  end

  // telegram state next values, cleared after the summary
  always_comb begin
    inside_token_next   = inside1;
    if (closing) inside_token_next = 1'b0;
    token_count_next    = cnt1;
    hex_value_next      = hv2;
    hex_stopped_next    = stop2;
    hex_digit_seen_next = seen2;
    if (in_end) begin
      inside_token_next   = 1'b0;
      token_count_next    = '0;
      hex_value_next      = '0;
      hex_stopped_next    = 1'b0;
      hex_digit_seen_next = 1'b0;
    end
  end

  // telegram state
  always_ff @(posedge clk) begin
    if (rst || (proc && in_end)) begin
      inside_token     <= 1'b0;
      token_count      <= '0;
      hex_value        <= '0;
      hex_stopped      <= 1'b0;
      hex_digit_seen   <= 1'b0;
      held_frequency   <= '1;
      held_start_angle <= '1;
      held_step        <= '1;
      running_angle    <= '0;
      emitted_points   <= '0;
    end else if (proc) begin
      inside_token     <= inside_token_next;
      token_count      <= token_count_next;
      hex_value        <= hex_value_next;
      hex_stopped      <= hex_stopped_next;
      hex_digit_seen   <= hex_digit_seen_next;
      held_frequency   <= held_frequency_next;
      held_start_angle <= held_start_angle_next;
      held_step        <= held_step_next;
      running_angle    <= running_angle_next;
      emitted_points   <= emitted_points_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_mem[wr_ptr] <= push0;
    end
    if (n_push == 2'd2) begin
      res_mem[wr_ptr + PTR_W'(1)] <= push1;
    end
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      fill <= fill + FILL_W'(n_push) - FILL_W'(pop);
    end
  end

  // output beat
  assign m_axis_tvalid = (fill != '0);
  assign m_axis_tuser  = res_mem[rd_ptr].kind;
  assign m_axis_tlast  = res_mem[rd_ptr].last;
  assign m_axis_tdata  = {7'd0,
                          res_mem[rd_ptr].angle_step,
                          res_mem[rd_ptr].start_angle,
                          res_mem[rd_ptr].scan_frequency,
                          res_mem[rd_ptr].status,
                          res_mem[rd_ptr].point_index,
                          res_mem[rd_ptr].range_mm};

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(lstp_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  // a byte is only processed with room for two results
  assert property (@(posedge clk) disable iff (rst)
    proc |-> (fill <= FILL_W'(lstp_pkg::RES_DEPTH - 2)))
    else $error("byte processed without queue room");

  // the summary clears the telegram state
  assert property (@(posedge clk) disable iff (rst)
    (proc && in_end) |=> (token_count == '0 && !inside_token && emitted_points == '0))
    else $error("telegram state not cleared after summary");

  // no more points than range fields
  assert property (@(posedge clk) disable iff (rst)
    32'(emitted_points) <= 32'(RANGE_POINTS))
    else $error("too many points emitted");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: scan telegram parser bench
// Streams ASCII telegrams into the parser and compares every range point and
// summary against a cycle-free model of the token reader and angle window.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_FIELDS     = lstp_pkg::EXPECTED_FIELDS_DEF;
  localparam int FIRST_RANGE  = lstp_pkg::FIRST_RANGE_FIELD_DEF;
  localparam int N_POINTS     = lstp_pkg::RANGE_POINTS_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_WAIT  = 4;
  localparam int DRAIN_WAIT   = 8;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_BYTES = 450;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // end_of_telegram
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // [15:0] range_mm, [22:16] point_index, [24:23] status,
                               // [40:25] scan_frequency, [72:41] start_angle,
                               // [88:73] angle_step
  logic        m_axis_tuser;   // kind
  logic        m_axis_tlast;   // last
  logic        cfg_valid;
  logic        cfg_ready;
  lstp_pkg::reg_index_t cfg_index;
  logic [31:0] cfg_data;

  // parser model state
  bit          in_token;
  int unsigned tok_count;
  bit [31:0]   hex_acc;
  bit          hex_halted;
  bit          hex_any;
  bit [15:0]   freq_hold;
  bit [31:0]   start_hold;
  bit [15:0]   step_hold;
  longint      run_angle;
  bit [6:0]    point_count;
  longint      win_min;
  longint      win_max;

  lstp_pkg::res_t results_due[$];
  bit [7:0]    tele_buf[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          hold_request = 1'b0;

  always #1 clk = ~clk;

  lidar_scan_telegram_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // hex character to nibble, returns 1 for a hex digit
  function automatic bit decode_nibble(input bit [7:0] c, output bit [3:0] n);
    n = 4'd0;
    if (c >= "0" && c <= "9") begin
      n = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      n = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      n = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // back to the state between telegrams
  function automatic void clear_telegram();
    in_token    = 1'b0;
    tok_count   = 0;
    hex_acc     = '0;
    hex_halted  = 1'b0;
    hex_any     = 1'b0;
    freq_hold   = '1;
    start_hold  = '1;
    step_hold   = '1;
    run_angle   = 0;
    point_count = '0;
  endfunction

  // end of a token: header capture or a range point through the window
  function automatic void close_field();
    int unsigned    pos;
    longint         a;
    longint         step;
    lstp_pkg::res_t r;
    in_token = 1'b0;
    if (tok_count == 0 || tok_count > N_FIELDS) return;
    pos = tok_count - 1;
    if (pos == lstp_pkg::FREQ_FIELD) begin
      if (hex_any) freq_hold = hex_acc[15:0];
    end else if (pos == lstp_pkg::START_FIELD) begin
      if (hex_any) start_hold = hex_acc;
      run_angle = longint'($signed(start_hold));
    end else if (pos == lstp_pkg::STEP_FIELD) begin
      if (hex_any) step_hold = hex_acc[15:0];
    end else if (pos >= FIRST_RANGE && pos < FIRST_RANGE + N_POINTS) begin
      a = run_angle;
      step = longint'(step_hold);
      run_angle = a + step;
      if (a + step >= win_min && a - step <= win_max) begin
        r = '0;
        r.kind = lstp_pkg::KIND_POINT;
        r.range_mm = hex_any ? hex_acc[15:0] : 16'd0;
        r.point_index = point_count;
        results_due.push_back(r);
        point_count++;
      end
    end
  endfunction

  // one accepted byte through the model
  function automatic void telegram_step(bit [7:0] b, bit eot);
    bit [3:0]       nib;
    bit             is_digit;
    lstp_pkg::res_t r;
    if (b == lstp_pkg::SPACE_CHAR) begin
      if (in_token) close_field();
    end else begin
      if (!in_token) begin
        in_token = 1'b1;
        if (tok_count <= N_FIELDS) tok_count++;
        hex_acc = '0;
        hex_halted = 1'b0;
        hex_any = 1'b0;
      end
      is_digit = decode_nibble(b, nib);
      if (!hex_halted) begin
        if (is_digit) begin
          hex_acc = {hex_acc[27:0], nib};
          hex_any = 1'b1;
        end else begin
          hex_halted = 1'b1;
        end
      end
    end
    if (eot) begin
      if (in_token) close_field();
      r = '0;
      r.kind = lstp_pkg::KIND_SUMMARY;
      if (tok_count < N_FIELDS) r.status = lstp_pkg::STATUS_TOO_FEW;
      else if (tok_count > N_FIELDS) r.status = lstp_pkg::STATUS_TOO_MANY;
      else r.status = lstp_pkg::STATUS_OK;
      r.scan_frequency = freq_hold;
      r.start_angle = start_hold;
      r.angle_step = step_hold;
      r.last = 1'b1;
      results_due.push_back(r);
      clear_telegram();
    end
  endfunction

  // sender: starts and ends at a falling edge, leaves tvalid up
  task automatic send_byte(bit [7:0] b, bit eot);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = eot;
    do @(posedge clk); while (!s_axis_tready);
    telegram_step(b, eot);
    bytes_sent++;
    @(negedge clk);
  endtask

  // wait until the parser has nothing left to say
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_window(lstp_pkg::reg_index_t idx, bit [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lstp_pkg::REG_MIN_ANGLE) win_min = longint'($signed(val));
    else win_max = longint'($signed(val));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // window settings: full, narrow, inverted extremes, single angle, random
  task automatic set_window(int sel);
    bit [31:0] lo;
    bit [31:0] hi;
    int        base;
    case (sel)
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        base = $urandom_range(0, 60000) - 30000;
        lo = base;
        hi = base + $urandom_range(0, 200000);
      end
      2: begin
        lo = 32'h7FFF_FFFF;
        hi = 32'h8000_0000;
      end
      3: begin
        lo = '0;
        hi = '0;
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
      end
    endcase
    settle();
    if ($urandom_range(0, 1)) begin
      write_window(lstp_pkg::REG_MIN_ANGLE, lo);
      write_window(lstp_pkg::REG_MAX_ANGLE, hi);
    end else begin
      write_window(lstp_pkg::REG_MAX_ANGLE, hi);
      write_window(lstp_pkg::REG_MIN_ANGLE, lo);
    end
  endtask

  function automatic bit [7:0] hex_char(bit [3:0] n);
    if (n < 10) return 8'("0" + n);
    if ($urandom_range(0, 1)) return 8'("a" + n - 10);
    return 8'("A" + n - 10);
  endfunction

  // any byte that is neither a hex digit nor a separator
  function automatic bit [7:0] junk_char();
    bit [7:0] c;
    bit [3:0] n;
    do c = 8'($urandom_range(0, 255));
    while (decode_nibble(c, n) || c == lstp_pkg::SPACE_CHAR);
    return c;
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) tele_buf.push_back(lstp_pkg::SPACE_CHAR);
  endfunction

  function automatic void add_hex(bit [31:0] v, int digits);
    for (int i = digits - 1; i >= 0; i--) tele_buf.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  // token with digits, sometimes none, sometimes trailing garbage
  function automatic void add_field(bit [31:0] v, int digits, int miss_odds);
    if ($urandom_range(0, miss_odds) == 0) begin
      tele_buf.push_back(junk_char());
      if ($urandom_range(0, 1)) tele_buf.push_back(hex_char(4'($urandom)));
    end else begin
      add_hex(v, digits);
      if ($urandom_range(0, 11) == 0) begin
        tele_buf.push_back(junk_char());
        tele_buf.push_back(hex_char(4'($urandom)));
      end
    end
  endfunction

  task automatic send_buffer();
    for (int i = 0; i < tele_buf.size(); i++) send_byte(tele_buf[i], i == tele_buf.size() - 1);
  endtask

  task automatic send_telegram(int n_fields, bit [15:0] freq, bit [31:0] start,
                               bit [15:0] step);
    tele_buf.delete();
    for (int k = 0; k < n_fields; k++) begin
      if (k > 0) add_spaces(($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1);
      else if ($urandom_range(0, 7) == 0) add_spaces($urandom_range(1, 2));
      if (k == lstp_pkg::FREQ_FIELD) begin
        add_field(freq, 4, 7);
      end else if (k == lstp_pkg::START_FIELD) begin
        // an extra leading digit pushes the top nibble out
        if ($urandom_range(0, 15) == 0) tele_buf.push_back(hex_char(4'($urandom)));
        add_field(start, 8, 7);
      end else if (k == lstp_pkg::STEP_FIELD) begin
        add_field(step, 4, 7);
      end else if (k >= FIRST_RANGE && k < FIRST_RANGE + N_POINTS) begin
        add_field($urandom,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 2), 9);
      end else begin
        tele_buf.push_back(($urandom_range(0, 2) == 0) ? junk_char() : hex_char(4'($urandom)));
      end
    end
    // telegram end: on the last token byte, or on trailing separators
    case ($urandom_range(0, 2))
      1: add_spaces(1);
      2: add_spaces($urandom_range(2, 3));
      default: ;
    endcase
    if (tele_buf.size() == 0) add_spaces(1);
    send_buffer();
  endtask

  task automatic send_noise(int n);
    tele_buf.delete();
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) tele_buf.push_back(lstp_pkg::SPACE_CHAR);
      else tele_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_buffer();
  endtask

  function automatic int pick_field_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return N_FIELDS;
    if (r == 7) return $urandom_range(N_FIELDS - 6, N_FIELDS - 1);
    if (r == 8) return $urandom_range(N_FIELDS + 1, N_FIELDS + 6);
    return $urandom_range(1, 40);
  endfunction

  // start near the lower window edge half of the time
  function automatic bit [31:0] pick_start();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'(win_min - longint'($urandom_range(0, 120000)));
  endfunction

  function automatic bit [15:0] pick_step();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 16'd0;
    if (r == 2) return 16'hFFFF;
    return 16'($urandom_range(1, 3000));
  endfunction

  // short tokens, empty telegrams, NUL and 0xFF, digit overflow, early stop
  task automatic test_token_edges();
    send_byte(lstp_pkg::SPACE_CHAR, 1'b1);
    send_byte("0", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(lstp_pkg::SPACE_CHAR, 1'b0);
    send_byte(lstp_pkg::SPACE_CHAR, 1'b0);
    send_byte(8'hFF, 1'b1);
    tele_buf.delete();
    tele_buf = '{"f", "F", "a", "A", "0", "9", "F", "f", "1", lstp_pkg::SPACE_CHAR};
    send_buffer();
    send_byte("7", 1'b0);
    send_byte("g", 1'b0);
    send_byte("3", 1'b1);
    send_byte("G", 1'b1);
  endtask

  // telegrams under narrow, inverted, single-angle and random windows
  task automatic test_random_telegrams();
    int phase;
    int first;
    phase = 0;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      set_window(1 + phase % 4);
      gaps_on = ($urandom_range(0, 4) != 0);
      send_telegram(pick_field_count(), 16'($urandom), pick_start(), pick_step());
      if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 24));
      phase++;
    end
  endtask

  // receiver holds off while a telegram of passing points streams in
  task automatic test_output_backpressure();
    set_window(0);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    send_telegram(N_FIELDS, 16'($urandom), 32'h0, 16'h0);
  endtask

  // receiver ready: random stall bursts and the long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    lstp_pkg::res_t got;
    lstp_pkg::res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind           = lstp_pkg::kind_t'(m_axis_tuser);
      got.range_mm       = m_axis_tdata[15:0];
      got.point_index    = m_axis_tdata[22:16];
      got.status         = lstp_pkg::status_t'(m_axis_tdata[24:23]);
      got.scan_frequency = m_axis_tdata[40:25];
      got.start_angle    = m_axis_tdata[72:41];
      got.angle_step     = m_axis_tdata[88:73];
      got.last           = m_axis_tlast;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t unexpected result: kind %0d range %0d index %0d", $realtime,
                   got.kind, got.range_mm, got.point_index);
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind || got.range_mm !== want.range_mm ||
            got.point_index !== want.point_index || got.status !== want.status ||
            got.scan_frequency !== want.scan_frequency ||
            got.start_angle !== want.start_angle || got.angle_step !== want.angle_step ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t result error (expected / actual):", $realtime);
            $display("  kind %0d/%0d range %0d/%0d index %0d/%0d status %0d/%0d",
                     want.kind, got.kind, want.range_mm, got.range_mm,
                     want.point_index, got.point_index, want.status, got.status);
            $display("  freq %h/%h start %h/%h step %h/%h last %0d/%0d",
                     want.scan_frequency, got.scan_frequency, want.start_angle,
                     got.start_angle, want.angle_step, got.angle_step, want.last, got.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("lidar_scan_telegram_parser_top: mismatch");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lstp_pkg::REG_MIN_ANGLE;
    cfg_data = '0;
    win_min = -64'sd2147483648;
    win_max = 64'sd2147483647;
    clear_telegram();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_token_edges();
    test_random_telegrams();
    test_output_backpressure();

    s_axis_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("lidar_scan_telegram_parser_top: match");
    end else begin
      $display("lidar_scan_telegram_parser_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lstp_pkg.sv
src/lidar_scan_telegram_parser_top.sv
bench/tb.sv
